// ----- rtl/core/rlee_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_pkg: shared types and constants of the run-length escape encoder
// Byte and count widths, register indexes, reset values and the flush
// descriptor that passes from the run tracker to the byte emitter.
// ----------------------------------------------------------------------------
package rlee_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 4;
	localparam int POS_W  = 4;
	localparam int IDX_W  = 2;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_MAX_EXTRA = 2'd0;
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [IDX_W-1:0] REG_ESCAPE    = 2'd2;

	localparam logic [CNT_W-1:0]  MAX_EXTRA_RESET = 4'd9;
	localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 4'd2;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'd33;

	localparam logic [CNT_W-1:0]  CNT_MIN    = 4'd1;
	localparam logic [CNT_W-1:0]  CNT_MAX    = 4'd9;
	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

	// Byte positions within an escape-coded run.
	localparam logic [POS_W-1:0] POS_VALUE  = 4'd0;
	localparam logic [POS_W-1:0] POS_ESCAPE = 4'd1;
	localparam logic [POS_W-1:0] POS_DIGIT  = 4'd2;

	// One run to be written out.
	typedef struct packed {
		logic              esc;
		logic [BYTE_W-1:0] value;
		logic [CNT_W-1:0]  count;
	} run_desc_t;

	// All the runs flushed by one input word: one or two of them.
	typedef struct packed {
		run_desc_t first;
		run_desc_t second;
		logic      two;
		logic      stream_end;
	} flush_job_t;

	function automatic logic [CNT_W-1:0] clamp_1_9(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < CNT_MIN) begin
			r = CNT_MIN;
		end else if (v > CNT_MAX) begin
			r = CNT_MAX;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/rlee_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_emitter: byte emitter of the run-length escape encoder
// Holds one flush job and writes its runs out through an output register,
// one byte per cycle unless stalled, as copies or as value, escape and digit.
// ----------------------------------------------------------------------------
module rlee_emitter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_load,
	input  rlee_pkg::flush_job_t       job,
	input  logic [rlee_pkg::BYTE_W-1:0] escape_byte,
	output logic                       job_free,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rlee_pkg::BYTE_W-1:0] out_byte,
	output logic                       last_of_item,
	output logic                       stream_done
);
	import rlee_pkg::*;

	logic              job_valid_q;
	flush_job_t        job_q;
	logic              sel_q;
	logic [POS_W-1:0]  pos_q;
	run_desc_t         cur;
	logic              advance;
	logic              emit;
	logic              desc_last;
	logic              job_last;
	logic [BYTE_W-1:0] byte_next;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              done_q;

	assign cur     = sel_q ? job_q.second : job_q.first;
	assign advance = !out_valid_q || out_ready;
	assign emit    = job_valid_q && advance;

	assign desc_last = cur.esc ? (pos_q == POS_DIGIT) : (pos_q == POS_W'(cur.count));
	assign job_last  = desc_last && (sel_q || !job_q.two);
	assign job_free  = !job_valid_q || (emit && job_last);

	always_comb begin
		byte_next = cur.value;
		if (cur.esc) begin
			case (pos_q)
				POS_VALUE:  byte_next = cur.value;
				POS_ESCAPE: byte_next = escape_byte;
				default:    byte_next = ASCII_ZERO + BYTE_W'(cur.count);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			pos_q       <= '0;
		end else if (job_load) begin
			job_valid_q <= 1'b1;
			sel_q       <= 1'b0;
			pos_q       <= '0;
		end else if (emit) begin
			if (job_last) begin
				job_valid_q <= 1'b0;
			end else if (desc_last) begin
				sel_q <= 1'b1;
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_next;
			last_q     <= job_last;
			done_q     <= job_last && job_q.stream_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = last_q;
	assign stream_done  = done_q;

endmodule

// ----- rtl/core/run_length_escape_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_escape_encoder: byte-stream run-length encoder with escapes
// Tracks the open run, turns each input word into the runs it closes and
// hands them to the emitter, which writes the compressed bytes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid / in_ready   | data_byte, end_of_stream
//  out     | output    | out_valid / out_ready | out_byte, last_of_item, stream_done
//  cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// A word that only grows or opens a run is taken back to back.
// A word that closes runs is taken too; its bytes leave one per cycle from
// the emitter while out_ready is high, up to ten, and the next closing word waits
// until the emitter is on the last byte of the current one.
// The output register lets the input run on while a word is not yet taken.
// Reset clears the run, the registers to their defaults and the output.
module run_length_escape_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rlee_pkg::BYTE_W-1:0] data_byte,
	input  logic                        end_of_stream,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rlee_pkg::BYTE_W-1:0] out_byte,
	output logic                        last_of_item,
	output logic                        stream_done,
	input  logic                        cfg_write,
	input  logic [rlee_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rlee_pkg::BYTE_W-1:0] cfg_data
);
	import rlee_pkg::*;

	logic [CNT_W-1:0]  max_extra_q;
	logic [CNT_W-1:0]  threshold_q;
	logic [BYTE_W-1:0] escape_q;

	logic [BYTE_W-1:0] run_value_q;
	logic [CNT_W-1:0]  run_count_q;
	logic              run_open_q;

	logic [CNT_W-1:0]  max_c;
	logic [CNT_W-1:0]  thr_c;
	logic              accept;
	logic              extend;
	logic              flush_old;
	logic [BYTE_W-1:0] new_value;
	logic [CNT_W-1:0]  new_count;
	run_desc_t         old_desc;
	run_desc_t         new_desc;
	flush_job_t        job;
	logic              job_load;
	logic              job_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_extra_q <= MAX_EXTRA_RESET;
			threshold_q <= THRESHOLD_RESET;
			escape_q    <= ESCAPE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_EXTRA: max_extra_q <= cfg_data[CNT_W-1:0];
				REG_THRESHOLD: threshold_q <= cfg_data[CNT_W-1:0];
				REG_ESCAPE:    escape_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign max_c  = clamp_1_9(max_extra_q);
	assign thr_c  = clamp_1_9(threshold_q);
	assign accept = in_valid && in_ready;

	assign extend    = run_open_q && (data_byte == run_value_q) && (run_count_q < max_c);
	assign flush_old = run_open_q && !extend;
	assign new_value = extend ? run_value_q : data_byte;
	assign new_count = extend ? (run_count_q + CNT_W'(1)) : '0;

	always_comb begin
		old_desc.esc   = run_count_q >= thr_c;
		old_desc.value = run_value_q;
		old_desc.count = run_count_q;
		new_desc.esc   = new_count >= thr_c;
		new_desc.value = new_value;
		new_desc.count = new_count;
		job.first      = flush_old ? old_desc : new_desc;
		job.second     = new_desc;
		job.two        = flush_old && end_of_stream;
		job.stream_end = end_of_stream;
	end

	// A word that closes no run and does not end the stream goes straight past the emitter.
	assign in_ready = job_free || !(flush_old || end_of_stream);
	assign job_load = accept && (flush_old || end_of_stream);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q <= '0;
			run_count_q <= '0;
			run_open_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_stream) begin
				run_value_q <= '0;
				run_count_q <= '0;
				run_open_q  <= 1'b0;
			end else begin
				run_value_q <= new_value;
				run_count_q <= new_count;
				run_open_q  <= 1'b1;
			end
		end
	end

	rlee_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_load     (job_load),
		.job          (job),
		.escape_byte  (escape_q),
		.job_free     (job_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_item (last_of_item),
		.stream_done  (stream_done)
	);

endmodule

// ----- rtl/core/rlee_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_checker: port-level checks of the run-length escape encoder
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module rlee_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [rlee_pkg::BYTE_W-1:0] data_byte,
	input logic                        end_of_stream,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rlee_pkg::BYTE_W-1:0] out_byte,
	input logic                        last_of_item,
	input logic                        stream_done
);
	import rlee_pkg::*;

	// A waiting input word holds.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte)
			&& $stable(end_of_stream))
		else $error("waiting input word changed");

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(last_of_item) && $stable(stream_done))
		else $error("stalled output word changed");

	// The end of the stream is always the end of a word's bytes.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_item)
		else $error("stream_done without last_of_item");

	// The bytes of one input word leave without gaps.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_item |=> out_valid)
		else $error("gap inside the bytes of one input word");

	// A final word always flushes at least one byte.
	a_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_stream |-> ##2 out_valid)
		else $error("end of stream produced no output");

endmodule

bind run_length_escape_encoder rlee_checker u_rlee_checker (.*);
